// ===== design/gdbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdbd_pkg - shared types and tables for the Gregorian day difference block
// Item payload structs, month tables and fixed widths used by every file.
// ----------------------------------------------------------------------------
package gdbd_pkg;

  localparam int DayW    = 5;
  localparam int MonthW  = 4;
  localparam int YearW   = 14;
  localparam int SerialW = 23;
  localparam int DiffW   = 23;

  // Largest magnitude of the reported difference
  localparam logic [DiffW:0] DiffLimit = 24'sd4194303;

  localparam logic [DayW-1:0] FebLeapLen  = 5'd29;
  localparam logic [DayW-1:0] FebPlainLen = 5'd28;
  localparam logic [MonthW-1:0] MonthJan  = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0] MonthDec  = 4'd12;

  typedef struct packed {
    logic [DayW-1:0]   first_day;
    logic [MonthW-1:0] first_month;
    logic [YearW-1:0]  first_year;
    logic [DayW-1:0]   last_day;
    logic [MonthW-1:0] last_month;
    logic [YearW-1:0]  last_year;
  } in_item_t;

  typedef struct packed {
    logic signed [DiffW-1:0] day_difference;
    logic                    date_invalid;
  } out_item_t;

  // Days in the months before the given month (common year)
  function automatic logic [8:0] month_start(input logic [MonthW-1:0] m);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Length of the given month (common year)
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] l;
    case (m)
      4'd1:    l = 5'd31;
      4'd2:    l = FebPlainLen;
      4'd3:    l = 5'd31;
      4'd4:    l = 5'd30;
      4'd5:    l = 5'd31;
      4'd6:    l = 5'd30;
      4'd7:    l = 5'd31;
      4'd8:    l = 5'd31;
      4'd9:    l = 5'd30;
      4'd10:   l = 5'd31;
      4'd11:   l = 5'd30;
      4'd12:   l = 5'd31;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

// ===== design/gdbd_serial.sv =====
// ----------------------------------------------------------------------------
// gdbd_serial - day serial number and validity check for one date
// Counts days from a fixed epoch, with leap-day correction, and flags
// dates that do not exist.
// ----------------------------------------------------------------------------
module gdbd_serial #(
  parameter int MAX_YEAR = 9999
) (
  input  logic [gdbd_pkg::DayW-1:0]    day,
  input  logic [gdbd_pkg::MonthW-1:0]  month,
  input  logic [gdbd_pkg::YearW-1:0]   year,
  output logic [gdbd_pkg::SerialW-1:0] serial,
  output logic                         date_ok
);
  import gdbd_pkg::*;

  localparam logic [16:0] MaxYearW = 17'(MAX_YEAR);

  logic [11:0]        q4;
  logic [22:0]        q4_prod;
  logic [7:0]         q100;
  logic [5:0]         q400;
  logic [11:0]        rem25;
  logic               div4;
  logic               div100;
  logic               leap;
  logic               year_ok;
  logic               month_ok;
  logic [DayW-1:0]    len;
  logic               leap_fix;
  logic [SerialW-1:0] y365;

  // Divide the year by 100 as (y/4)/25, reciprocal 1311/2^15 is exact here
  assign q4      = year[YearW-1:2];
  assign q4_prod = 23'(q4) * 23'd1311;
  assign q100    = q4_prod[22:15];
  assign q400    = q100[7:2];
  assign rem25   = q4 - (12'(q100) * 12'd25);

  // Leap-year test
  assign div4   = (year[1:0] == 2'b00);
  assign div100 = div4 && (rem25 == 12'd0);
  assign leap   = (div4 && !div100) || (div100 && (q100[1:0] == 2'b00));

  // Range checks
  assign year_ok  = (year != '0) && ({3'b000, year} <= MaxYearW);
  assign month_ok = (month >= MonthJan) && (month <= MonthDec);
  assign len      = (month == MonthFeb && leap) ? FebLeapLen : month_len(month);
  assign date_ok  = year_ok && month_ok && (day != '0) && (day <= len);

  // Leap day of this year not yet passed
  assign leap_fix = leap && ((month < MonthFeb) ||
                             (month == MonthFeb && day <= FebPlainLen));

  // Serial number
  assign y365   = SerialW'(year) * SerialW'(365);
  assign serial = y365 + SerialW'(q4) - SerialW'(q100) + SerialW'(q400)
                + SerialW'(month_start(month)) + SerialW'(day)
                - SerialW'(leap_fix);

endmodule

// ===== design/gregorian_days_between_dates.sv =====
// Pipeline: two register stages; an accepted item waits in the input register,
// and its result is registered into out_data when the pipeline advances.
// Throughput: one item per cycle; the input register and the result
// register advance together whenever the result side is not stalled.
// Reset: rst_n synchronous, active low, empties both pipeline stages.
// ----------------------------------------------------------------------------
// gregorian_days_between_dates - signed day count between two dates
// Registers each date pair, converts both dates to day serial numbers,
// subtracts, saturates and flags invalid dates in the result register.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gdbd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gdbd_pkg::out_item_t  out_data
);
  import gdbd_pkg::*;

  logic      s1_valid_r,  s1_valid_nxt;
  in_item_t  s1_data_r,   s1_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r,  out_data_nxt;

  logic               advance;
  logic               in_take;
  logic [SerialW-1:0] first_serial;
  logic [SerialW-1:0] last_serial;
  logic               first_ok;
  logic               last_ok;
  logic signed [DiffW:0] diff;
  logic signed [DiffW:0] diff_sat;

  // Pipeline moves when the result register is free or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Convert both dates
  gdbd_serial #(.MAX_YEAR(MAX_YEAR)) u_first (
    .day     (s1_data_r.first_day),
    .month   (s1_data_r.first_month),
    .year    (s1_data_r.first_year),
    .serial  (first_serial),
    .date_ok (first_ok)
  );

  gdbd_serial #(.MAX_YEAR(MAX_YEAR)) u_last (
    .day     (s1_data_r.last_day),
    .month   (s1_data_r.last_month),
    .year    (s1_data_r.last_year),
    .serial  (last_serial),
    .date_ok (last_ok)
  );

  // Subtract and clamp to the result range
  assign diff = $signed({1'b0, last_serial}) - $signed({1'b0, first_serial});

  always_comb begin
    if (diff > $signed(DiffLimit)) begin
      diff_sat = $signed(DiffLimit);
    end else if (diff < -$signed(DiffLimit)) begin
      diff_sat = -$signed(DiffLimit);
    end else begin
      diff_sat = diff;
    end
  end

  // Next values of both stages
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_data_nxt   = s1_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      if (first_ok && last_ok) begin
        out_data_nxt.day_difference = diff_sat[DiffW-1:0];
        out_data_nxt.date_invalid   = 1'b0;
      end else begin
        out_data_nxt.day_difference = '0;
        out_data_nxt.date_invalid   = 1'b1;
      end
      s1_valid_nxt = in_take;
    end
    // Load a new item into the empty or emptying input register
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_data_nxt  = in_data;
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
